[hdl/wra_pkg.sv]
// Shared types, constants and rounding for the waveform running average.
`timescale 1ns / 1ps

package wra_pkg;

    localparam int FRAME_POINTS  = 8192;
    localparam int FRACTION_BITS = 16;
    localparam int STORE_W       = 8 + FRACTION_BITS;
    localparam int ADDR_W        = $clog2(FRAME_POINTS);
    localparam int DEPTH_W       = 9;
    localparam int INDEX_W       = 13;

    typedef struct packed {
        logic [7:0]         sample_a;
        logic [7:0]         sample_b;
        logic [INDEX_W-1:0] point_index;
        logic               restart;
        logic               last_point;
    } wra_in_t;

    typedef struct packed {
        logic [7:0]         avg_a;
        logic [7:0]         avg_b;
        logic [INDEX_W-1:0] point_out;
    } wra_out_t;

    typedef struct packed {
        logic               start;
        logic [ADDR_W-1:0]  addr;
        logic [7:0]         sample;
        logic [DEPTH_W-1:0] n;
        logic               wr_en;
    } lane_ctrl_t;

    typedef struct packed {
        logic               done;
        logic [STORE_W-1:0] avg;
    } lane_stat_t;

    function automatic logic [7:0] round8(input logic [STORE_W-1:0] avg);
        logic [STORE_W:0] sum;
        logic [8:0]       r;
        sum = {1'b0, avg} + (STORE_W+1)'(1 << (FRACTION_BITS - 1));
        r   = sum[STORE_W:FRACTION_BITS];
        return r[8] ? 8'hFF : r[7:0];
    endfunction

endpackage

[hdl/wra_lane.sv]
// One channel lane: per-point store, weight multiply and serial divide.
`timescale 1ns / 1ps

module wra_lane
    import wra_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  lane_ctrl_t ctrl,
    output lane_stat_t stat
);

    localparam logic [2:0] L_IDLE = 3'd0;
    localparam logic [2:0] L_RD   = 3'd1;
    localparam logic [2:0] L_MUL  = 3'd2;
    localparam logic [2:0] L_DIV  = 3'd3;
    localparam logic [2:0] L_WR   = 3'd4;

    localparam int PROD_W = STORE_W + DEPTH_W;
    localparam int NUM_W  = STORE_W + DEPTH_W + 1;
    localparam int CNT_W  = $clog2(STORE_W);

    logic [STORE_W-1:0] mem_ram [FRAME_POINTS];

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [STORE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [7:0]         sample_reg;
    logic [DEPTH_W-1:0] n_reg;
    logic               wr_en_reg;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [DEPTH_W-1:0] rem_reg, rem_next;
    logic [STORE_W-1:0] sh_reg, sh_next;

    logic [NUM_W-1:0]   num;
    logic [DEPTH_W:0]   trial;
    logic [DEPTH_W:0]   diff;
    logic               qbit;

    always_comb begin
        num = NUM_W'(prod_reg)
            + NUM_W'({sample_reg, {FRACTION_BITS{1'b0}}})
            + NUM_W'(n_reg[DEPTH_W-1:1]);
        trial = {rem_reg, sh_reg[STORE_W-1]};
        diff  = trial - {1'b0, n_reg};
        qbit  = (trial >= {1'b0, n_reg});
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        sh_next    = sh_reg;
        case (state_reg)
            L_IDLE: begin
                if (ctrl.start) begin
                    state_next = L_RD;
                end
            end
            L_RD: begin
                // weight one ignores the stored value, which may not exist yet
                if (n_reg == DEPTH_W'(1)) begin
                    prod_next = '0;
                end else begin
                    prod_next = PROD_W'(rd_data_reg) * PROD_W'(n_reg - DEPTH_W'(1));
                end
                state_next = L_MUL;
            end
            L_MUL: begin
                // quotient fits STORE_W bits, so the top part is below n
                rem_next   = num[NUM_W-2:STORE_W];
                sh_next    = num[STORE_W-1:0];
                cnt_next   = '0;
                state_next = L_DIV;
            end
            L_DIV: begin
                rem_next = qbit ? diff[DEPTH_W-1:0] : trial[DEPTH_W-1:0];
                sh_next  = {sh_reg[STORE_W-2:0], qbit};
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(STORE_W - 1)) begin
                    state_next = L_WR;
                end
            end
            L_WR: begin
                state_next = L_IDLE;
            end
            default: begin
                state_next = L_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        sh_reg   <= sh_next;
        if (ctrl.start && state_reg == L_IDLE) begin
            addr_reg   <= ctrl.addr;
            sample_reg <= ctrl.sample;
            n_reg      <= ctrl.n;
            wr_en_reg  <= ctrl.wr_en;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.start && state_reg == L_IDLE) begin
            rd_data_reg <= mem_ram[ctrl.addr];
        end
        if (state_reg == L_WR && wr_en_reg) begin
            mem_ram[addr_reg] <= sh_reg;
        end
    end

    assign stat.done = (state_reg == L_WR);
    assign stat.avg  = sh_reg;

endmodule

[hdl/wra_merge.sv]
// Merge stage: rounds both lane averages into the output register, or gives zero for an out-of-range point.
`timescale 1ns / 1ps

module wra_merge
    import wra_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  logic               in_range,
    input  logic [INDEX_W-1:0] point,
    input  logic [STORE_W-1:0] avg_a,
    input  logic [STORE_W-1:0] avg_b,
    output logic               free,
    output logic               m_valid,
    input  logic               m_ready,
    output wra_out_t           m_data
);

    logic     valid_reg, valid_next;
    wra_out_t data_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg.avg_a     <= in_range ? round8(avg_a) : 8'd0;
            data_reg.avg_b     <= in_range ? round8(avg_b) : 8'd0;
            data_reg.point_out <= point;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

[hdl/waveform_running_average.sv]
// Per-point running average of two channels: top level with frame counter.
// From input transfer to m_valid an item goes through read, multiply, load,
// 8 + FRACTION_BITS divide steps (one quotient bit a cycle per lane), write, merge.
// s_ready is low until the lane results load into the merge register.
// Reset (aresetn low, synchronous): depth 1, frame count 0, no result pending.
// Stored averages are not cleared by reset.
`timescale 1ns / 1ps

module waveform_running_average
    import wra_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [DEPTH_W-1:0] cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  wra_in_t            s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output wra_out_t           m_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BUSY = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] frame_count_reg, frame_count_next;
    logic [INDEX_W-1:0] point_reg;
    logic               in_range_reg;

    logic               accept;
    logic [DEPTH_W-1:0] eff_depth;
    logic [DEPTH_W-1:0] fc;
    logic [DEPTH_W:0]   fc_inc;
    logic [DEPTH_W-1:0] n_val;
    logic               in_range;
    logic               lanes_done;
    logic               merge_free;
    logic               merge_load;

    lane_ctrl_t ctrl_a, ctrl_b;
    lane_stat_t stat_a, stat_b;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        eff_depth = (depth_reg == '0) ? DEPTH_W'(1) : depth_reg;
        fc        = s_data.restart ? '0 : frame_count_reg;
        fc_inc    = {1'b0, fc} + (DEPTH_W+1)'(1);
        n_val     = (fc_inc > {1'b0, eff_depth}) ? eff_depth : fc_inc[DEPTH_W-1:0];
        in_range  = (32'(s_data.point_index) < 32'(FRAME_POINTS));

        frame_count_next = frame_count_reg;
        if (accept) begin
            frame_count_next = fc;
            if (s_data.last_point) begin
                frame_count_next = (fc < eff_depth) ? fc_inc[DEPTH_W-1:0] : eff_depth;
            end
        end
    end

    always_comb begin
        ctrl_a.start  = accept;
        ctrl_a.addr   = ADDR_W'(s_data.point_index);
        ctrl_a.sample = s_data.sample_a;
        ctrl_a.n      = n_val;
        ctrl_a.wr_en  = in_range;
        ctrl_b        = ctrl_a;
        ctrl_b.sample = s_data.sample_b;
    end

    wra_lane u_lane_a (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_a),
        .stat    (stat_a)
    );

    wra_lane u_lane_b (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl_b),
        .stat    (stat_b)
    );

    assign lanes_done = stat_a.done && stat_b.done;
    assign merge_load = (state_reg == S_HOLD) && merge_free;

    wra_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (merge_load),
        .in_range (in_range_reg),
        .point    (point_reg),
        .avg_a    (stat_a.avg),
        .avg_b    (stat_b.avg),
        .free     (merge_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = S_BUSY;
                end
            end
            S_BUSY: begin
                if (lanes_done) begin
                    state_next = S_HOLD;
                end
            end
            S_HOLD: begin
                if (merge_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            depth_reg       <= DEPTH_W'(1);
            frame_count_reg <= '0;
        end else begin
            state_reg       <= state_next;
            frame_count_reg <= frame_count_next;
            if (cfg_we) begin
                depth_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            point_reg    <= s_data.point_index;
            in_range_reg <= in_range;
        end
    end

    // lanes run in lockstep
    assert property (@(posedge aclk) disable iff (!aresetn)
        stat_a.done == stat_b.done)
        else $error("lane done mismatch");

    // a transfer starts lane work
    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg == S_BUSY) && !s_ready)
        else $error("transfer did not start lanes");

    // a new result only comes from a finished item
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_HOLD))
        else $error("result without finished item");

    // lanes only finish while an item is in flight
    assert property (@(posedge aclk) disable iff (!aresetn)
        lanes_done |-> (state_reg == S_BUSY))
        else $error("lane finished while idle");

endmodule

[sim/waveform_running_average_tb.sv]
// Testbench for the waveform running average: per-point average prediction with frame stimulus.
`timescale 1ns / 1ps

module waveform_running_average_tb;
    import wra_pkg::*;

    class running_avg_scoreboard;
        int unsigned        depth_reg;
        int unsigned        frame_cnt;
        logic [STORE_W-1:0] store_a [FRAME_POINTS];
        logic [STORE_W-1:0] store_b [FRAME_POINTS];
        bit                 written [FRAME_POINTS];
        wra_out_t           expected_avgs[$];
        int unsigned        errors;

        function new();
            depth_reg = 1;
            frame_cnt = 0;
            errors    = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void set_depth(logic [DEPTH_W-1:0] v);
            depth_reg = v;
        endfunction

        function int unsigned eff_depth();
            return (depth_reg == 0) ? 1 : depth_reg;
        endfunction

        function int unsigned weight(bit restart);
            int unsigned n;
            n = (restart ? 0 : frame_cnt) + 1;
            return (n > eff_depth()) ? eff_depth() : n;
        endfunction

        // Never let a point with weight above one read an entry that was never written.
        function wra_in_t make_safe(wra_in_t d);
            if (weight(d.restart) > 1 && !written[d.point_index])
                d.restart = 1'b1;
            return d;
        endfunction

        function logic [STORE_W-1:0] blend(logic [STORE_W-1:0] avg, logic [7:0] smp,
                                           int unsigned n);
            longint unsigned s;
            longint unsigned a;
            longint unsigned num;
            s = longint'(smp) << FRACTION_BITS;
            a = avg;
            if (n <= 1)
                return s[STORE_W-1:0];
            num = a * (n - 1) + s + (n / 2);
            num = num / n;
            return num[STORE_W-1:0];
        endfunction

        function logic [7:0] round_to_byte(logic [STORE_W-1:0] avg);
            longint unsigned r;
            r = (longint'(avg) + (longint'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            return (r > 255) ? 8'hFF : r[7:0];
        endfunction

        function void note_input(wra_in_t d);
            int unsigned n;
            wra_out_t    res;
            if (d.restart)
                frame_cnt = 0;
            n = weight(1'b0);
            res.avg_a     = 8'd0;
            res.avg_b     = 8'd0;
            res.point_out = d.point_index;
            if (int'(d.point_index) < FRAME_POINTS) begin
                store_a[d.point_index] = blend(store_a[d.point_index], d.sample_a, n);
                store_b[d.point_index] = blend(store_b[d.point_index], d.sample_b, n);
                written[d.point_index] = 1'b1;
                res.avg_a = round_to_byte(store_a[d.point_index]);
                res.avg_b = round_to_byte(store_b[d.point_index]);
            end
            if (d.last_point)
                frame_cnt = (frame_cnt < eff_depth()) ? frame_cnt + 1 : eff_depth();
            expected_avgs.push_back(res);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(wra_out_t r);
            wra_out_t e;
            if (expected_avgs.size() == 0) begin
                report($sformatf("unexpected result for point %0d", r.point_out));
            end else begin
                e = expected_avgs.pop_front();
                if (r.avg_a !== e.avg_a)
                    report($sformatf("point %0d avg_a %0d, want %0d",
                                     e.point_out, r.avg_a, e.avg_a));
                if (r.avg_b !== e.avg_b)
                    report($sformatf("point %0d avg_b %0d, want %0d",
                                     e.point_out, r.avg_b, e.avg_b));
                if (r.point_out !== e.point_out)
                    report($sformatf("point_out %0d, want %0d", r.point_out, e.point_out));
            end
        endtask

        function int unsigned pending();
            return expected_avgs.size();
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [DEPTH_W-1:0] cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    wra_in_t            s_data;
    logic               m_valid;
    logic               m_ready;
    wra_out_t           m_data;

    running_avg_scoreboard sb;
    bit                    idle_on;
    logic [INDEX_W-1:0]    frame_base;
    int unsigned           frame_len;

    waveform_running_average u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("[waveform_running_average] ERROR");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    // Receiver stalls in random bursts.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic wra_in_t make_point(logic [7:0] a, logic [7:0] b,
                                           logic [INDEX_W-1:0] idx, bit restart, bit last);
        wra_in_t d;
        d.sample_a    = a;
        d.sample_b    = b;
        d.point_index = idx;
        d.restart     = restart;
        d.last_point  = last;
        return d;
    endfunction

    // Called at a falling edge; returns at a falling edge with s_valid still high.
    task automatic send_point(input wra_in_t d);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        d = sb.make_safe(d);
        s_valid <= 1'b1;
        s_data  <= d;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(d);
        @(negedge aclk);
    endtask

    task automatic end_burst();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_depth(input logic [DEPTH_W-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        sb.set_depth(v);
        @(negedge aclk);
    endtask

    task automatic run_depth_phase(input logic [DEPTH_W-1:0] depth, input int unsigned n_items);
        int unsigned sent;
        int unsigned k;
        bit          first;
        wra_in_t     d;
        drain_results();
        write_depth(depth);
        first = 1'b0;
        if (frame_len == 0 || $urandom_range(0, 1) == 0) begin
            frame_len  = $urandom_range(2, 8);
            frame_base = INDEX_W'($urandom_range(0, FRAME_POINTS - frame_len));
            first      = 1'b1;
        end
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 6) == 0) begin
                d = make_point(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               INDEX_W'($urandom_range(0, FRAME_POINTS - 1)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                send_point(d);
                sent++;
            end else begin
                for (k = 0; k < frame_len; k++) begin
                    d = make_point(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                   frame_base + INDEX_W'(k),
                                   (first && k == 0) || $urandom_range(0, 40) == 0,
                                   k == frame_len - 1);
                    send_point(d);
                    sent++;
                end
                first = 1'b0;
            end
        end
        end_burst();
    endtask

    initial begin
        int unsigned i;
        int unsigned wait_cycles;
        sb         = new();
        idle_on    = 1'b1;
        frame_len  = 0;
        frame_base = '0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_valid    = 1'b0;
        s_data     = '0;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset depth of one: each point takes its sample.
        send_point(make_point(8'd0, 8'd255, '0, 1'b1, 1'b0));
        send_point(make_point(8'd255, 8'd0, INDEX_W'(FRAME_POINTS - 1), 1'b0, 1'b1));
        end_burst();

        // Weight grows to the depth and saturates there.
        drain_results();
        write_depth(9'd4);
        for (i = 0; i < 5; i++) begin
            send_point(make_point(i[0] ? 8'd0 : 8'd255, i[0] ? 8'd255 : 8'd0,
                                  '0, i == 0, 1'b0));
            send_point(make_point(i[0] ? 8'd255 : 8'd0, i[0] ? 8'd0 : 8'd255,
                                  INDEX_W'(FRAME_POINTS - 1), 1'b0, 1'b1));
        end
        end_burst();

        // Depth lowered below the frame count.
        drain_results();
        write_depth(9'd2);
        send_point(make_point(8'd128, 8'd127, '0, 1'b0, 1'b0));
        send_point(make_point(8'd1, 8'd254, INDEX_W'(FRAME_POINTS - 1), 1'b0, 1'b1));
        end_burst();

        // Depth zero acts as one.
        drain_results();
        write_depth(9'd0);
        send_point(make_point(8'd77, 8'd200, '0, 1'b0, 1'b0));
        send_point(make_point(8'd255, 8'd255, INDEX_W'(FRAME_POINTS - 1), 1'b0, 1'b1));
        end_burst();

        // Largest depth, restart on the last point of a frame.
        drain_results();
        write_depth(9'd511);
        send_point(make_point(8'd10, 8'd20, '0, 1'b0, 1'b0));
        send_point(make_point(8'd30, 8'd40, INDEX_W'(FRAME_POINTS - 1), 1'b1, 1'b1));
        end_burst();

        run_depth_phase(9'd1, 60);
        run_depth_phase(9'd256, 60);
        run_depth_phase(9'd3, 60);
        run_depth_phase(9'd511, 60);
        run_depth_phase(9'd0, 60);
        run_depth_phase(9'd2, 60);
        run_depth_phase(DEPTH_W'($urandom_range(1, 256)), 60);
        idle_on = 1'b0;
        run_depth_phase(DEPTH_W'($urandom_range(0, 511)), 60);

        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 20000) begin
            @(negedge aclk);
            wait_cycles++;
        end
        repeat (40) @(negedge aclk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("[waveform_running_average] OK");
        else
            $display("[waveform_running_average] ERROR");
        $finish;
    end

endmodule
